@@ src/nga_pkg.sv @@
// Shared types and constants for the direct-sum gravity block.
// No dependencies; every other file depends on this package.
`default_nettype none
package nga_pkg;
	localparam int POSW  = 32;           // position word
	localparam int MASSW = 32;           // mass word
	localparam int GW    = 32;           // gravity constant word
	localparam int CNTW  = 7;            // body_count register
	localparam int IDXW  = 6;            // body_index field
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam int RW    = 33;           // |R| magnitude
	localparam int MULW  = 34;           // shared multiplier operand
	localparam int PRODW = 2 * MULW;
	localparam int D2W   = 68;
	localparam int ROOTW = 34;
	localparam int D3W   = 102;
	localparam int GMW   = 64;
	localparam int NUMW  = 97;           // G*M*|R| before the fraction shift
	localparam int QBITS = 51;           // quotient bits kept below the cap
	localparam int TERMW = 51;
	localparam int ACCW  = 58;
	localparam int OUTW  = 48;

	localparam logic [TERMW-1:0] TERM_CAP = TERMW'(1) << 50;
	localparam logic signed [ACCW-1:0] ACC_OUT_MAX = (ACCW'(1) << (OUTW - 1)) - ACCW'(1);
	localparam logic signed [ACCW-1:0] ACC_OUT_MIN = -ACC_OUT_MAX - ACCW'(1);

	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BODY_COUNT = 1'b1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [POSW-1:0]  x;
		logic [POSW-1:0]  y;
		logic [POSW-1:0]  z;
		logic [MASSW-1:0] mass;
	} body_t;
endpackage
`default_nettype wire

@@ src/nga_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on nga_pkg for field widths.
`default_nettype none
interface nga_req_if;
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic [nga_pkg::IDXW-1:0]       body_index;
	logic signed [nga_pkg::POSW-1:0] pos_x;
	logic signed [nga_pkg::POSW-1:0] pos_y;
	logic signed [nga_pkg::POSW-1:0] pos_z;
	logic [nga_pkg::MASSW-1:0]      mass;
	modport source (output valid, operation, body_index, pos_x, pos_y, pos_z, mass,
		input ready);
	modport sink (input valid, operation, body_index, pos_x, pos_y, pos_z, mass,
		output ready);
endinterface

interface nga_rsp_if;
	logic                            valid;
	logic                            ready;
	logic signed [nga_pkg::OUTW-1:0] accel_x;
	logic signed [nga_pkg::OUTW-1:0] accel_y;
	logic signed [nga_pkg::OUTW-1:0] accel_z;
	logic                            saturated;
	modport source (output valid, accel_x, accel_y, accel_z, saturated, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, saturated, output ready);
endinterface
`default_nettype wire

@@ src/nga_body_mem.sv @@
// Body table: one write port, one registered read port.
// Depends on nga_pkg for the entry type.
`default_nettype none
module nga_body_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire nga_pkg::body_t  wdata,
	input  wire logic [AW-1:0]   raddr,
	output nga_pkg::body_t       rdata
);
	import nga_pkg::*;

	body_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ src/nga_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on nga_pkg for widths.
`default_nettype none
module nga_sqrt (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [nga_pkg::D2W-1:0] value,
	output logic                       done,
	output logic [nga_pkg::ROOTW-1:0]  root
);
	import nga_pkg::*;

	logic [D2W-1:0] op_q, res_q, one_q, sum;
	logic [5:0]     cnt_q;
	logic           busy_q;

	assign sum  = res_q + one_q;
	assign root = res_q[ROOTW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(ROOTW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= value;
			res_q <= '0;
			one_q <= D2W'(1) << (2 * (ROOTW - 1));
		end else if (busy_q) begin
			if (op_q >= sum) begin
				op_q  <= op_q - sum;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end
endmodule
`default_nettype wire

@@ src/nga_div.sv @@
// Restoring divider for one force term, one quotient bit per cycle,
// with an early cap when the quotient cannot fit. Depends on nga_pkg.
`default_nettype none
module nga_div #(
	parameter int NW = 113
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [NW-1:0]            num,
	input  wire logic [nga_pkg::D3W-1:0]  den,
	output logic                          done,
	output logic [nga_pkg::TERMW-1:0]     term,
	output logic                          sat
);
	import nga_pkg::*;

	localparam int CW = (NW > D3W + 1) ? NW : D3W + 1;

	logic [D3W:0]     rem_q, trial;
	logic [D3W-1:0]   den_q;
	logic [QBITS-1:0] nbits_q, q_q;
	logic [5:0]       cnt_q;
	logic             busy_q, cap_q, ge, over;

	assign trial = {rem_q[D3W-1:0], nbits_q[QBITS-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign over  = cap_q || (TERMW'(q_q) > TERM_CAP);
	assign term  = over ? TERM_CAP : TERMW'(q_q);
	assign sat   = over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				// A high part already at or above the divisor means the quotient
				// reaches twice the cap, so no iterations are needed.
				if (CW'(num >> QBITS) >= CW'(den)) begin
					done <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(QBITS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cap_q   <= CW'(num >> QBITS) >= CW'(den);
			rem_q   <= (D3W + 1)'(num >> QBITS);
			nbits_q <= num[QBITS-1:0];
			den_q   <= den;
			q_q     <= '0;
		end else if (busy_q) begin
			rem_q   <= ge ? trial - {1'b0, den_q} : trial;
			nbits_q <= nbits_q << 1;
			q_q     <= {q_q[QBITS-2:0], ge};
		end
	end
endmodule
`default_nettype wire

@@ src/nbody_gravity_acceleration_top.sv @@
// Channel   Dir  Payload
// req       in   operation, body_index, pos_x/y/z, mass
// rsp       out  accel_x/y/z, saturated
// cfg       in   cfg_we, cfg_index, cfg_data
//
// A query walks the body table one entry at a time; the time per body in use
// is set mostly by the divider, run once per axis, and by the square root;
// an excluded entry is skipped.
// One query is in flight at a time; the result register lets the next
// request in while a result waits on rsp.ready. Reset is asynchronous and
// clears control state only; the body table is undefined until written.
// Depends on nga_pkg, nga_if, nga_body_mem, nga_sqrt and nga_div.
`default_nettype none
module nbody_gravity_acceleration_top #(
	parameter int MAX_BODIES = 64,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	nga_req_if.sink                             req,
	nga_rsp_if.source                           rsp,
	input  wire logic                           cfg_we,
	input  wire logic [nga_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [nga_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nga_pkg::*;

	localparam int AW   = $clog2(MAX_BODIES);
	localparam int KW   = $clog2(MAX_BODIES + 1);
	localparam int DNW  = NUMW + FRAC_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PICK = 4'd1;
	localparam logic [3:0] S_DIFF = 4'd2;
	localparam logic [3:0] S_SQ   = 4'd3;
	localparam logic [3:0] S_SQRT = 4'd4;
	localparam logic [3:0] S_D3   = 4'd5;
	localparam logic [3:0] S_NUM  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0]              state_q;
	logic [GW-1:0]           g_q;
	logic [CNTW-1:0]         bcount_q;
	logic [KW-1:0]           k_q, used_q;
	logic [IDXW-1:0]         excl_q;
	logic signed [POSW-1:0]  px_q, py_q, pz_q;
	logic [RW-1:0]           rmag_q [3];
	logic [2:0]              rneg_q;
	logic [MASSW-1:0]        mass_q;
	logic [D2W-1:0]          d2_q, d2_sum;
	logic [ROOTW-1:0]        d_q;
	logic [D3W-1:0]          d3_q;
	logic [GMW-1:0]          gm_q;
	logic [NUMW-1:0]         num_q, num_sum;
	logic [1:0]              axis_q, cnt_q;
	logic [MULW-1:0]         mul_a, mul_b;
	logic [PRODW-1:0]        mul_p, prod_q;
	logic signed [ACCW-1:0]  acc_q [3];
	logic signed [ACCW-1:0]  term_s;
	logic signed [ACCW-1:0]  clamp [3];
	logic [2:0]              clamp_hit;
	logic                    sat_q;
	logic                    out_valid_q;
	logic signed [OUTW-1:0]  out_x_q, out_y_q, out_z_q;
	logic                    out_sat_q;

	body_t                   rd_body;
	body_t                   wr_body;
	logic                    wr_en;
	logic                    req_acc;
	logic signed [RW-1:0]    rdiff [3];

	logic                    sqrt_start, sqrt_done;
	logic [ROOTW-1:0]        sqrt_root;
	logic                    div_start, div_done, div_sat;
	logic [TERMW-1:0]        div_term;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign wr_en     = req_acc && (req.operation == OP_WRITE)
		&& (32'(req.body_index) < MAX_BODIES);
	assign wr_body   = '{x: req.pos_x, y: req.pos_y, z: req.pos_z, mass: req.mass};

	nga_body_mem #(.DEPTH(MAX_BODIES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(req.body_index)),
		.wdata (wr_body),
		.raddr (k_q[AW-1:0]),
		.rdata (rd_body)
	);

	assign d2_sum     = d2_q + prod_q;
	assign sqrt_start = (state_q == S_SQ) && (cnt_q == 2'd3) && (d2_sum != '0);

	nga_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (d2_sum),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign num_sum   = num_q + (NUMW'(prod_q) << 32);
	assign div_start = (state_q == S_NUM) && (cnt_q == 2'd2);

	nga_div #(.NW(DNW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({num_sum, {FRAC_BITS{1'b0}}}),
		.den    (d3_q),
		.done   (div_done),
		.term   (div_term),
		.sat    (div_sat)
	);

	// Body minus point, 33-bit signed.
	assign rdiff[0] = RW'(signed'(rd_body.x)) - RW'(px_q);
	assign rdiff[1] = RW'(signed'(rd_body.y)) - RW'(py_q);
	assign rdiff[2] = RW'(signed'(rd_body.z)) - RW'(pz_q);

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_SQ) begin
			if (cnt_q != 2'd3) begin
				mul_a = MULW'(rmag_q[cnt_q]);
				mul_b = MULW'(rmag_q[cnt_q]);
			end
		end else if (state_q == S_D3) begin
			priority case (cnt_q)
				2'd0: begin
					mul_a = d2_q[MULW-1:0];
					mul_b = MULW'(d_q);
				end
				2'd1: begin
					mul_a = d2_q[D2W-1:MULW];
					mul_b = MULW'(d_q);
				end
				default: begin
					mul_a = MULW'(g_q);
					mul_b = MULW'(mass_q);
				end
			endcase
		end else if (state_q == S_NUM) begin
			mul_a = (cnt_q == 2'd0) ? MULW'(gm_q[31:0]) : MULW'(gm_q[63:32]);
			mul_b = MULW'(rmag_q[axis_q]);
		end
	end

	assign mul_p  = mul_a * mul_b;
	assign term_s = rneg_q[axis_q] ? -ACCW'(div_term) : ACCW'(div_term);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			clamp_hit[a] = 1'b0;
			clamp[a]     = acc_q[a];
			if (acc_q[a] > ACC_OUT_MAX) begin
				clamp[a]     = ACC_OUT_MAX;
				clamp_hit[a] = 1'b1;
			end else if (acc_q[a] < ACC_OUT_MIN) begin
				clamp[a]     = ACC_OUT_MIN;
				clamp_hit[a] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			g_q         <= GW'(65536);
			bcount_q    <= '0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			cnt_q       <= '0;
			axis_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRAVITY:    g_q      <= cfg_data[GW-1:0];
					REG_BODY_COUNT: bcount_q <= cfg_data[CNTW-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && req.operation == OP_QUERY) begin
						k_q     <= '0;
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (k_q >= used_q) begin
						state_q <= S_OUT;
					end else if (32'(k_q) == 32'(excl_q)) begin
						k_q <= k_q + KW'(1);
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (d2_sum == '0) begin
							k_q     <= k_q + KW'(1);
							state_q <= S_PICK;
						end else begin
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						cnt_q   <= '0;
						state_q <= S_D3;
					end
				end
				S_D3: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						cnt_q   <= '0;
						axis_q  <= '0;
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd2) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						cnt_q <= '0;
						if (axis_q == 2'd2) begin
							k_q     <= k_q + KW'(1);
							state_q <= S_PICK;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_NUM;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == S_IDLE && req_acc) begin
			px_q   <= req.pos_x;
			py_q   <= req.pos_y;
			pz_q   <= req.pos_z;
			excl_q <= req.body_index;
			used_q <= (32'(bcount_q) > MAX_BODIES) ? KW'(MAX_BODIES) : KW'(bcount_q);
			sat_q  <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				acc_q[a] <= '0;
			end
		end
		if (state_q == S_DIFF) begin
			mass_q <= rd_body.mass;
			for (int a = 0; a < 3; a++) begin
				rneg_q[a] <= rdiff[a][RW-1];
				rmag_q[a] <= rdiff[a][RW-1] ? -rdiff[a] : rdiff[a];
			end
		end
		if (state_q == S_SQ) begin
			if (cnt_q == 2'd1) begin
				d2_q <= prod_q;
			end else if (cnt_q != 2'd0) begin
				d2_q <= d2_sum;
			end
		end
		if (state_q == S_SQRT && sqrt_done) begin
			d_q <= sqrt_root;
		end
		if (state_q == S_D3) begin
			priority case (cnt_q)
				2'd1: d3_q <= D3W'(prod_q);
				2'd2: d3_q <= d3_q + (D3W'(prod_q) << MULW);
				2'd3: gm_q <= prod_q[GMW-1:0];
				default: ;
			endcase
		end
		if (state_q == S_NUM && cnt_q == 2'd1) begin
			num_q <= NUMW'(prod_q);
		end
		if (state_q == S_DIV && div_done) begin
			acc_q[axis_q] <= acc_q[axis_q] + term_s;
			sat_q         <= sat_q | div_sat;
		end
		if (state_q == S_OUT && (!out_valid_q || rsp.ready)) begin
			out_x_q   <= OUTW'(clamp[0]);
			out_y_q   <= OUTW'(clamp[1]);
			out_z_q   <= OUTW'(clamp[2]);
			out_sat_q <= sat_q | (|clamp_hit);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.accel_x   = out_x_q;
	assign rsp.accel_y   = out_y_q;
	assign rsp.accel_z   = out_z_q;
	assign rsp.saturated = out_sat_q;
endmodule
`default_nettype wire

@@ src/nga_checker.sv @@
// Port-level checks for the gravity block, bound to its top level.
// Depends on nga_pkg and nbody_gravity_acceleration_top.
`default_nettype none
module nga_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          req_operation,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [nga_pkg::OUTW-1:0]      rsp_accel_x
);
	import nga_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_accel_x))
		else $error("stalled result changed");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_operation == OP_WRITE && !rsp_valid |=> !rsp_valid)
		else $error("write transaction produced a result");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_operation == OP_QUERY |=> !req_ready)
		else $error("request taken while a query is in progress");
endmodule

bind nbody_gravity_acceleration_top nga_checker u_nga_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_operation (req.operation),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_accel_x   (rsp.accel_x)
);
`default_nettype wire
